// File: design/matrix_keypad_scanner_top_assert.svh
// Assertion macros for the keypad scanner top level.
`ifndef MATRIX_KEYPAD_SCANNER_TOP_ASSERT_SVH
`define MATRIX_KEYPAD_SCANNER_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk and suspended while arst_n is low.
`define KPS_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("keypad scanner check failed");

// Next-cycle implication, sampled on clk and suspended while arst_n is low.
`define KPS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("keypad scanner check failed");

`endif

// File: design/kps_pkg.sv
// Shared types and constants of the keypad scanner.
package kps_pkg;

	localparam int CMD_W     = 2;
	localparam int ROW_W     = 2;
	localparam int COL_N     = 4;
	localparam int CODE_W    = 8;
	localparam int WAIT_W    = 3;
	localparam int TIMER_W   = 32;
	localparam int DEB_W     = 16;
	localparam int KEYMAP_W  = 64;
	localparam int CFG_IDX_W = 2;

	localparam logic [CMD_W-1:0] CMD_TICK = 2'd0;
	localparam logic [CMD_W-1:0] CMD_EDGE = 2'd1;
	localparam logic [CMD_W-1:0] CMD_READ = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_KEYMAP_LO = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_KEYMAP_HI = 2'd2;

	localparam logic [DEB_W-1:0] DEBOUNCE_RESET = 16'd20;

	typedef struct packed {
		logic              push;
		logic              pop;
		logic [CODE_W-1:0] wdata;
	} kps_fifo_req_t;

	typedef struct packed {
		logic              empty;
		logic              full;
		logic [CODE_W-1:0] head;
	} kps_fifo_stat_t;

endpackage

// File: design/kps_if.sv
// Request channels of the keypad scanner: items, results and register writes.
interface kps_item_if;
	logic                          valid;
	logic                          ready;
	logic [kps_pkg::CMD_W-1:0]     command;
	logic [kps_pkg::ROW_W-1:0]     row_index;
	logic [kps_pkg::COL_N-1:0]     column_levels;

	modport source (output valid, command, row_index, column_levels, input ready);
	modport sink (input valid, command, row_index, column_levels, output ready);
endinterface

interface kps_result_if;
	logic                          valid;
	logic                          ready;
	logic                          edge_accepted;
	logic                          no_column_found;
	logic                          key_dropped;
	logic                          key_valid;
	logic [kps_pkg::CODE_W-1:0]    key_code;
	logic [kps_pkg::WAIT_W-1:0]    keys_waiting;

	modport source (output valid, edge_accepted, no_column_found, key_dropped, key_valid,
		key_code, keys_waiting, input ready);
	modport sink (input valid, edge_accepted, no_column_found, key_dropped, key_valid,
		key_code, keys_waiting, output ready);
endinterface

interface kps_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [kps_pkg::CFG_IDX_W-1:0] index;
	logic [kps_pkg::KEYMAP_W-1:0]  data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// File: design/kps_cfg_regs.sv
// Configuration registers and keymap lookup of the keypad scanner.
module kps_cfg_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	kps_cfg_if.sink                      cfg,
	input  logic [3:0]                   key,
	output logic [kps_pkg::DEB_W-1:0]    debounce_ms,
	output logic [kps_pkg::CODE_W-1:0]   key_code
);

	logic [kps_pkg::DEB_W-1:0]    debounce_q;
	logic [kps_pkg::KEYMAP_W-1:0] keymap_lo_q;
	logic [kps_pkg::KEYMAP_W-1:0] keymap_hi_q;
	logic [kps_pkg::KEYMAP_W-1:0] word;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q  <= kps_pkg::DEBOUNCE_RESET;
			keymap_lo_q <= '0;
			keymap_hi_q <= '0;
		end else if (cfg.valid) begin
			case (cfg.index)
				kps_pkg::CFG_DEBOUNCE:  debounce_q  <= cfg.data[kps_pkg::DEB_W-1:0];
				kps_pkg::CFG_KEYMAP_LO: keymap_lo_q <= cfg.data;
				kps_pkg::CFG_KEYMAP_HI: keymap_hi_q <= cfg.data;
				default: ;
			endcase
		end
	end

	// Keys 8 to 15 live in the high word; the low three bits pick the byte.
	assign word        = key[3] ? keymap_hi_q : keymap_lo_q;
	assign key_code    = word[{key[2:0], 3'b000} +: kps_pkg::CODE_W];
	assign debounce_ms = debounce_q;

endmodule

// File: design/kps_debounce.sv
// Millisecond timer since the last row edge and the debounce decision.
module kps_debounce (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      tick,
	input  logic                      row_edge,
	input  logic [kps_pkg::DEB_W-1:0] debounce_ms,
	output logic                      settled
);

	logic [kps_pkg::TIMER_W-1:0] since_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			since_q <= '0;
		end else if (row_edge) begin
			since_q <= '0;
		end else if (tick && (since_q != '1)) begin
			since_q <= since_q + 1'b1;
		end
	end

	assign settled = since_q >= {{(kps_pkg::TIMER_W-kps_pkg::DEB_W){1'b0}}, debounce_ms};

endmodule

// File: design/kps_key_fifo.sv
// Circular key code queue with a registered head read.
module kps_key_fifo #(
	parameter int DEPTH = 5,
	parameter int CNT_W = 3
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  kps_pkg::kps_fifo_req_t req,
	output kps_pkg::kps_fifo_stat_t stat,
	output logic [CNT_W-1:0]      count,
	output logic [CNT_W-1:0]      count_next
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [kps_pkg::CODE_W-1:0] mem [DEPTH];
	logic [PTR_W-1:0]           rd_ptr_q;
	logic [PTR_W-1:0]           wr_ptr_q;
	logic [PTR_W-1:0]           rd_next;
	logic [PTR_W-1:0]           wr_next;
	logic [CNT_W-1:0]           count_q;
	logic [kps_pkg::CODE_W-1:0] head_q;

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] ptr);
		ptr_inc = (ptr == PTR_W'(DEPTH - 1)) ? '0 : ptr + 1'b1;
	endfunction

	assign rd_next    = req.pop ? ptr_inc(rd_ptr_q) : rd_ptr_q;
	assign wr_next    = req.push ? ptr_inc(wr_ptr_q) : wr_ptr_q;
	assign count_next = count_q + CNT_W'(req.push) - CNT_W'(req.pop);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= '0;
			wr_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			rd_ptr_q <= rd_next;
			wr_ptr_q <= wr_next;
			count_q  <= count_next;
		end
	end

	always_ff @(posedge clk) begin
		if (req.push) begin
			mem[wr_ptr_q] <= req.wdata;
		end
	end

	// The head register follows the next read slot; a write to that slot in the
	// same cycle is forwarded, since the array read still sees the old entry.
	always_ff @(posedge clk) begin
		if (req.push && (wr_ptr_q == rd_next)) begin
			head_q <= req.wdata;
		end else begin
			head_q <= mem[rd_next];
		end
	end

	assign stat.empty = count_q == '0;
	assign stat.full  = count_q == CNT_W'(DEPTH);
	assign stat.head  = head_q;
	assign count      = count_q;

endmodule

// File: design/matrix_keypad_scanner_top.sv
// Keypad scanner: one item per clock through an input register and a result register
// while the result side keeps up. Each request (millisecond tick, row falling edge or key
// read) is taken into an input register, decided there against the debounce timer, the
// keymap and the key queue, and its single result lands in the output register when no
// earlier result is left waiting there. A new request is accepted in every clock, also while
// a finished result waits to be taken; only a result left waiting with another request
// already held in the input register stops intake.
// The key queue holds KEY_FIFO_DEPTH codes; its single write port and registered head read
// keep pace with one request per clock. Configuration writes are always ready and should be
// made only while no request is in flight.
module matrix_keypad_scanner_top #(
	parameter int KEY_FIFO_DEPTH = 5
) (
	input  logic           clk,
	input  logic           arst_n,
	kps_item_if.sink       item,
	kps_result_if.source   result,
	kps_cfg_if.sink        cfg
);

	localparam int CNT_W = $clog2(KEY_FIFO_DEPTH + 1);
	localparam logic [kps_pkg::WAIT_W-1:0] WAIT_FULL = KEY_FIFO_DEPTH[kps_pkg::WAIT_W-1:0];

	typedef struct packed {
		logic       found;
		logic [1:0] col;
	} col_pick_t;

	logic                          valid_s1;
	logic [kps_pkg::CMD_W-1:0]     cmd_s1;
	logic [kps_pkg::ROW_W-1:0]     row_s1;
	logic [kps_pkg::COL_N-1:0]     cols_s1;

	logic                          res_valid_q;
	logic                          edge_accepted_q;
	logic                          no_column_q;
	logic                          key_dropped_q;
	logic                          key_valid_q;
	logic [kps_pkg::CODE_W-1:0]    key_code_q;
	logic [kps_pkg::WAIT_W-1:0]    keys_waiting_q;

	logic                          advance;
	logic                          settled;
	logic [kps_pkg::DEB_W-1:0]     debounce_ms;
	logic [kps_pkg::CODE_W-1:0]    map_code;
	col_pick_t                     pick;
	logic                          is_edge;
	logic                          accepted;
	logic                          no_column;
	logic                          dropped;
	kps_pkg::kps_fifo_req_t        fifo_req;
	kps_pkg::kps_fifo_stat_t       fifo_stat;
	logic [CNT_W-1:0]              count_q;
	logic [CNT_W-1:0]              count_next;
	logic [CNT_W+2:0]              count_ext;

	// Lowest numbered column whose line is low.
	function automatic col_pick_t first_low(input logic [kps_pkg::COL_N-1:0] levels);
		col_pick_t r;
		r = '0;
		for (int c = kps_pkg::COL_N - 1; c >= 0; c--) begin
			if (!levels[c]) begin
				r.found = 1'b1;
				r.col   = 2'(c);
			end
		end
		return r;
	endfunction

	assign advance    = valid_s1 && (!res_valid_q || result.ready);
	assign item.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			cmd_s1  <= item.command;
			row_s1  <= item.row_index;
			cols_s1 <= item.column_levels;
		end
	end

	kps_cfg_regs u_cfg (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.key         ({row_s1, pick.col}),
		.debounce_ms (debounce_ms),
		.key_code    (map_code)
	);

	kps_debounce u_debounce (
		.clk         (clk),
		.arst_n      (arst_n),
		.tick        (advance && (cmd_s1 == kps_pkg::CMD_TICK)),
		.row_edge    (advance && is_edge),
		.debounce_ms (debounce_ms),
		.settled     (settled)
	);

	assign pick      = first_low(cols_s1);
	assign is_edge   = cmd_s1 == kps_pkg::CMD_EDGE;
	assign accepted  = is_edge && settled;
	assign no_column = accepted && !pick.found;
	assign dropped   = accepted && pick.found && fifo_stat.full;

	assign fifo_req.push  = advance && accepted && pick.found && !fifo_stat.full;
	assign fifo_req.pop   = advance && (cmd_s1 == kps_pkg::CMD_READ) && !fifo_stat.empty;
	assign fifo_req.wdata = map_code;

	kps_key_fifo #(
		.DEPTH (KEY_FIFO_DEPTH),
		.CNT_W (CNT_W)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (fifo_req),
		.stat       (fifo_stat),
		.count      (count_q),
		.count_next (count_next)
	);

	assign count_ext = (CNT_W + 3)'(count_next);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			edge_accepted_q <= accepted;
			no_column_q     <= no_column;
			key_dropped_q   <= dropped;
			key_valid_q     <= fifo_req.pop;
			key_code_q      <= fifo_req.pop ? fifo_stat.head : '0;
			keys_waiting_q  <= count_ext[kps_pkg::WAIT_W-1:0];
		end
	end

	assign result.valid           = res_valid_q;
	assign result.edge_accepted   = edge_accepted_q;
	assign result.no_column_found = no_column_q;
	assign result.key_dropped     = key_dropped_q;
	assign result.key_valid       = key_valid_q;
	assign result.key_code        = key_code_q;
	assign result.keys_waiting    = keys_waiting_q;

`include "matrix_keypad_scanner_top_assert.svh"

	`KPS_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CNT_W'(KEY_FIFO_DEPTH))
	`KPS_ASSERT_NOW(a_nocol_needs_edge, res_valid_q && no_column_q, edge_accepted_q && !key_dropped_q)
	`KPS_ASSERT_NOW(a_drop_when_full, res_valid_q && key_dropped_q, keys_waiting_q == WAIT_FULL)
	`KPS_ASSERT_NEXT(a_pop_shrinks, fifo_req.pop && !fifo_req.push, count_q == $past(count_q) - CNT_W'(1))

endmodule

// File: tb/matrix_keypad_scanner_top_test.sv
// Self-checking testbench for the keypad scanner, comparing each result against a local prediction.
module matrix_keypad_scanner_top_test;

	localparam int KEY_DEPTH = 5;
	localparam int CYCLE_LIMIT = 1000000;
	localparam logic [kps_pkg::CMD_W-1:0] CMD_SPARE = 2'd3;
	localparam logic [kps_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

	typedef struct packed {
		logic                       edge_accepted;
		logic                       no_column_found;
		logic                       key_dropped;
		logic                       key_valid;
		logic [kps_pkg::CODE_W-1:0] key_code;
		logic [kps_pkg::WAIT_W-1:0] keys_waiting;
	} scan_result_t;

	logic clk;
	logic arst_n;

	kps_item_if   item_ch ();
	kps_result_if result_ch ();
	kps_cfg_if    cfg_ch ();

	matrix_keypad_scanner_top #(.KEY_FIFO_DEPTH(KEY_DEPTH)) u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (result_ch),
		.cfg    (cfg_ch)
	);

	// Local copy of the scanner state and its registers.
	logic [kps_pkg::TIMER_W-1:0]  ms_since_edge;
	logic [kps_pkg::CODE_W-1:0]   stored_keys [KEY_DEPTH];
	int unsigned                  key_head;
	int unsigned                  key_count;
	logic [kps_pkg::DEB_W-1:0]    debounce_cfg;
	logic [kps_pkg::KEYMAP_W-1:0] keymap_lo_cfg;
	logic [kps_pkg::KEYMAP_W-1:0] keymap_hi_cfg;

	scan_result_t pending_results [$];
	bit           idle_on;
	int           mismatch_count = 0;
	int           cycle_count = 0;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic scan_result_t predict_scan(logic [kps_pkg::CMD_W-1:0] cmd,
			logic [kps_pkg::ROW_W-1:0] row, logic [kps_pkg::COL_N-1:0] levels);
		scan_result_t r;
		int col;
		int c;
		logic [3:0] key;
		logic [kps_pkg::KEYMAP_W-1:0] word;
		r = '0;
		col = -1;
		case (cmd)
			kps_pkg::CMD_TICK: begin
				if (ms_since_edge != '1)
					ms_since_edge++;
			end
			kps_pkg::CMD_EDGE: begin
				if (ms_since_edge >= debounce_cfg) begin
					r.edge_accepted = 1'b1;
					for (c = kps_pkg::COL_N - 1; c >= 0; c--)
						if (!levels[c])
							col = c;
					if (col < 0) begin
						r.no_column_found = 1'b1;
					end else if (key_count >= KEY_DEPTH) begin
						r.key_dropped = 1'b1;
					end else begin
						key = {row, col[1:0]};
						word = key[3] ? keymap_hi_cfg : keymap_lo_cfg;
						stored_keys[(key_head + key_count) % KEY_DEPTH] = word[key[2:0] * 8 +: 8];
						key_count++;
					end
				end
				ms_since_edge = '0;
			end
			kps_pkg::CMD_READ: begin
				if (key_count > 0) begin
					r.key_valid = 1'b1;
					r.key_code = stored_keys[key_head];
					key_head = (key_head + 1) % KEY_DEPTH;
					key_count--;
				end
			end
			default: ;
		endcase
		r.keys_waiting = key_count[kps_pkg::WAIT_W-1:0];
		return r;
	endfunction

	function automatic logic [kps_pkg::COL_N-1:0] rand_levels();
		// Now and then no column is held low at all.
		return ($urandom_range(0, 6) == 0) ? 4'hF : 4'($urandom);
	endfunction

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		$display("ERROR cycle %0d: %s got 0x%0h expected 0x%0h", cycle_count, what, got, want);
		mismatch_count++;
	endtask

	task automatic send_item(logic [kps_pkg::CMD_W-1:0] cmd, logic [kps_pkg::ROW_W-1:0] row,
			logic [kps_pkg::COL_N-1:0] levels);
		int gap;
		gap = idle_on ? $urandom_range(0, 17) : 0;
		repeat (gap) begin
			@(negedge clk);
			item_ch.valid <= 1'b0;
		end
		@(negedge clk);
		item_ch.valid <= 1'b1;
		item_ch.command <= cmd;
		item_ch.row_index <= row;
		item_ch.column_levels <= levels;
		do @(posedge clk); while (!item_ch.ready);
		pending_results.push_back(predict_scan(cmd, row, levels));
	endtask

	// Lets every request in flight come back so that registers may be written.
	task automatic settle_block();
		@(negedge clk);
		item_ch.valid <= 1'b0;
		while (pending_results.size() > 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic [kps_pkg::CFG_IDX_W-1:0] idx,
			logic [kps_pkg::KEYMAP_W-1:0] value);
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= value;
		do @(posedge clk); while (!cfg_ch.ready);
		case (idx)
			kps_pkg::CFG_DEBOUNCE:  debounce_cfg = value[kps_pkg::DEB_W-1:0];
			kps_pkg::CFG_KEYMAP_LO: keymap_lo_cfg = value;
			kps_pkg::CFG_KEYMAP_HI: keymap_hi_cfg = value;
			default: ;
		endcase
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	// Reset settings: a 20 ms debounce and an all-zero keymap, so a stored code reads as 0.
	task automatic test_reset_settings();
		send_item(kps_pkg::CMD_EDGE, 2'd0, 4'h0);
		repeat (20) send_item(kps_pkg::CMD_TICK, 2'd3, 4'hF);
		send_item(kps_pkg::CMD_EDGE, 2'd0, 4'hE);
		send_item(kps_pkg::CMD_READ, 2'd0, 4'h0);
	endtask

	task automatic test_key_paths();
		settle_block();
		write_reg(kps_pkg::CFG_DEBOUNCE, 64'd0);
		write_reg(kps_pkg::CFG_KEYMAP_LO, 64'hF7E6D5C4B3A29180);
		write_reg(kps_pkg::CFG_KEYMAP_HI, 64'h7F6E5D4C3B2A1908);
		send_item(kps_pkg::CMD_READ, 2'd3, 4'hF);
		send_item(kps_pkg::CMD_EDGE, 2'd0, 4'b0000);
		send_item(kps_pkg::CMD_EDGE, 2'd1, 4'b1101);
		send_item(kps_pkg::CMD_EDGE, 2'd2, 4'b1011);
		send_item(kps_pkg::CMD_EDGE, 2'd3, 4'b0111);
		send_item(kps_pkg::CMD_EDGE, 2'd3, 4'b1111);
		send_item(kps_pkg::CMD_EDGE, 2'd2, 4'b1110);
		// The queue is full now, so this key is lost.
		send_item(kps_pkg::CMD_EDGE, 2'd0, 4'b0111);
		send_item(CMD_SPARE, 2'd3, 4'hF);
		repeat (6) send_item(kps_pkg::CMD_READ, 2'd0, 4'h0);
	endtask

	task automatic test_spare_register();
		settle_block();
		write_reg(CFG_SPARE, '1);
		send_item(kps_pkg::CMD_EDGE, 2'd3, 4'b0111);
		send_item(kps_pkg::CMD_READ, 2'd1, 4'h5);
	endtask

	task automatic test_debounce_limits();
		bit saved_idle;
		saved_idle = idle_on;
		idle_on = 1'b0;
		settle_block();
		// The largest threshold: a short quiet time never reaches it.
		write_reg(kps_pkg::CFG_DEBOUNCE, 64'hFFFF);
		send_item(kps_pkg::CMD_EDGE, 2'd0, 4'h0);
		repeat (5) send_item(kps_pkg::CMD_TICK, 2'($urandom), 4'($urandom));
		send_item(kps_pkg::CMD_EDGE, 2'd1, 4'b1011);
		settle_block();
		write_reg(kps_pkg::CFG_DEBOUNCE, 64'd40);
		repeat (39) send_item(kps_pkg::CMD_TICK, 2'($urandom), 4'($urandom));
		send_item(kps_pkg::CMD_EDGE, 2'd1, 4'b1011);
		repeat (40) send_item(kps_pkg::CMD_TICK, 2'($urandom), 4'($urandom));
		send_item(kps_pkg::CMD_EDGE, 2'd1, 4'b1011);
		idle_on = saved_idle;
		settle_block();
		write_reg(kps_pkg::CFG_DEBOUNCE, 64'd3);
		repeat (2) send_item(kps_pkg::CMD_TICK, 2'd0, 4'h0);
		send_item(kps_pkg::CMD_EDGE, 2'd2, 4'b1101);
		repeat (3) send_item(kps_pkg::CMD_TICK, 2'd0, 4'h0);
		send_item(kps_pkg::CMD_EDGE, 2'd2, 4'b1101);
		repeat (2) send_item(kps_pkg::CMD_READ, 2'd0, 4'h0);
	endtask

	task automatic test_random_traffic();
		int phase;
		int sent;
		int pick;
		int n;
		logic [kps_pkg::DEB_W-1:0] deb;
		for (phase = 0; phase < 8; phase++) begin
			settle_block();
			idle_on = (phase % 4) != 1;
			case (phase % 4)
				0: deb = '0;
				1: deb = kps_pkg::DEB_W'($urandom_range(1, 4));
				2: deb = kps_pkg::DEB_W'($urandom_range(0, 8));
				default: deb = kps_pkg::DEB_W'($urandom_range(2, 12));
			endcase
			write_reg(kps_pkg::CFG_DEBOUNCE, kps_pkg::KEYMAP_W'(deb));
			write_reg(kps_pkg::CFG_KEYMAP_LO, (phase == 5) ? '1 : {$urandom, $urandom});
			write_reg(kps_pkg::CFG_KEYMAP_HI, (phase == 5) ? '1 : {$urandom, $urandom});
			sent = 0;
			while (sent < 200) begin
				pick = $urandom_range(0, 99);
				if (pick < 50) begin
					// A key press: quiet time on the rows, then the falling edge.
					n = $urandom_range(0, deb + 2);
					repeat (n) send_item(kps_pkg::CMD_TICK, 2'($urandom), 4'($urandom));
					send_item(kps_pkg::CMD_EDGE, 2'($urandom), rand_levels());
					sent += n + 1;
				end else if (pick < 85) begin
					send_item(kps_pkg::CMD_READ, 2'($urandom), 4'($urandom));
					sent++;
				end else if (pick < 95) begin
					send_item(kps_pkg::CMD_W'($urandom_range(0, 2)), 2'($urandom),
						rand_levels());
					sent++;
				end else begin
					send_item(CMD_SPARE, 2'($urandom), 4'($urandom));
				end
			end
		end
	endtask

	// Result side: while idle_on is set, a stall of random length follows each result taken.
	initial begin : result_stalls
		int stall;
		stall = 0;
		result_ch.ready = 1'b0;
		wait (arst_n);
		forever begin
			@(negedge clk);
			if (stall > 0) begin
				result_ch.ready <= 1'b0;
				stall--;
			end else begin
				result_ch.ready <= 1'b1;
			end
			@(posedge clk);
			if (result_ch.valid && result_ch.ready)
				stall = idle_on ? $urandom_range(0, 17) : 0;
		end
	end

	always @(posedge clk) begin : check_results
		scan_result_t want;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (pending_results.size() == 0) begin
				report_mismatch("result with no request pending", 1, 0);
			end else begin
				want = pending_results.pop_front();
				if (result_ch.edge_accepted !== want.edge_accepted)
					report_mismatch("edge_accepted", result_ch.edge_accepted, want.edge_accepted);
				if (result_ch.no_column_found !== want.no_column_found)
					report_mismatch("no_column_found", result_ch.no_column_found,
						want.no_column_found);
				if (result_ch.key_dropped !== want.key_dropped)
					report_mismatch("key_dropped", result_ch.key_dropped, want.key_dropped);
				if (result_ch.key_valid !== want.key_valid)
					report_mismatch("key_valid", result_ch.key_valid, want.key_valid);
				if (result_ch.key_code !== want.key_code)
					report_mismatch("key_code", result_ch.key_code, want.key_code);
				if (result_ch.keys_waiting !== want.keys_waiting)
					report_mismatch("keys_waiting", result_ch.keys_waiting, want.keys_waiting);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("matrix_keypad_scanner_top_test: FAIL");
			$finish;
		end
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		item_ch.valid = 1'b0;
		item_ch.command = kps_pkg::CMD_TICK;
		item_ch.row_index = '0;
		item_ch.column_levels = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = kps_pkg::CFG_DEBOUNCE;
		cfg_ch.data = '0;
		idle_on = 1'b1;
		ms_since_edge = '0;
		key_head = 0;
		key_count = 0;
		debounce_cfg = kps_pkg::DEBOUNCE_RESET;
		keymap_lo_cfg = '0;
		keymap_hi_cfg = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_reset_settings();
		test_key_paths();
		test_spare_register();
		test_debounce_limits();
		test_random_traffic();

		settle_block();
		repeat (8) @(posedge clk);
		if (mismatch_count == 0)
			$display("matrix_keypad_scanner_top_test: PASS");
		else
			$display("matrix_keypad_scanner_top_test: FAIL");
		$finish;
	end

endmodule
